[sv/conditional_edge_dilation_3x3_core_macros.svh]
// Assertion macros shared by the dilation core.
// Each macro takes a label, the clock, the reset and the checked expressions.
`ifndef CONDITIONAL_EDGE_DILATION_3X3_CORE_MACROS_SVH
`define CONDITIONAL_EDGE_DILATION_3X3_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define CED3X3_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define CED3X3_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CED3X3_ASSERT_IMP(name, clk, rst, ante, cons)
`define CED3X3_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

[sv/ced3x3_pkg.sv]
`default_nettype none
package ced3x3_pkg;

  // Default frame limits
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Widest values the geometry registers can hold
  localparam int WIDTH_REG_MAX  = 4095;
  localparam int HEIGHT_REG_MAX = 8191;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  // Register reset values
  localparam logic [7:0]  THRESHOLD_RST = 8'd0;
  localparam logic [11:0] WIDTH_RST     = 12'd640;
  localparam logic [12:0] HEIGHT_RST    = 13'd480;

  // Depth of the queue between front and back
  localparam int QDEPTH = 4;

  // Bits needed to index n entries (at least one)
  function automatic int bits_for(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // One classified pixel: the shifted window, its coordinates and the
  // set of results it produces (bit 0 centre cell, bit 1 right edge,
  // bit 2 bottom row, bit 3 bottom right corner).
  typedef struct packed {
    logic [8:0][7:0] win;
    logic [11:0]     row;
    logic [10:0]     col;
    logic            r_ge1;
    logic            r_ge2;
    logic            c_ge1;
    logic            c_ge2;
    logic [3:0]      mask;
  } entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

[sv/ced3x3_ram.sv]
`default_nettype none
module ced3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [ced3x3_pkg::bits_for(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [ced3x3_pkg::bits_for(DEPTH)-1:0]  raddr,
  output logic      [WIDTH-1:0]                         rdata
);
  import ced3x3_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/ced3x3_queue.sv]
`default_nettype none
module ced3x3_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ced3x3_pkg::entry_t  push_entry,
  input  wire logic                pop,
  output ced3x3_pkg::entry_t       head,
  output ced3x3_pkg::qstat_t       qstat
);
  import ced3x3_pkg::*;

  localparam int PW = bits_for(QDEPTH);

  entry_t           entries [QDEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;

  assign head        = entries[rptr];
  assign qstat.full  = (count == (PW+1)'(QDEPTH));
  assign qstat.empty = (count == '0);

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/ced3x3_front.sv]
`default_nettype none
module ced3x3_front #(
  parameter int MAX_WIDTH  = ced3x3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ced3x3_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,      // [7:0] pixel
  input  wire logic                restart,
  input  wire logic [11:0]         frame_width,
  input  wire logic [12:0]         frame_height,
  input  wire ced3x3_pkg::qstat_t  qstat,
  output logic                     q_push,
  output ced3x3_pkg::entry_t       q_entry
);
  import ced3x3_pkg::*;

  localparam int WLIM = (MAX_WIDTH < WIDTH_REG_MAX) ? MAX_WIDTH : WIDTH_REG_MAX;
  localparam int HLIM = (MAX_HEIGHT < HEIGHT_REG_MAX) ? MAX_HEIGHT : HEIGHT_REG_MAX;
  localparam int CW   = bits_for(WLIM);
  localparam int RW   = bits_for(HLIM);

  logic [CW-1:0]   last_col;
  logic [RW-1:0]   last_row;
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic            in_acc;

  logic            s1_valid;
  logic            s1_adv;
  logic [7:0]      s1_pix;
  logic [CW-1:0]   s1_col;
  logic [11:0]     s1_row_out;
  logic [10:0]     s1_col_out;
  logic            s1_r_ge1;
  logic            s1_r_ge2;
  logic            s1_c_ge1;
  logic            s1_c_ge2;
  logic [3:0]      s1_mask;

  logic [15:0]     rd_word;
  logic [15:0]     col_word;
  logic [15:0]     wr_word;
  logic            fwd;
  logic [15:0]     fwd_word;
  logic [7:0]      upper_old;
  logic [7:0]      mid_old;

  logic [8:0][7:0] win;
  logic [8:0][7:0] win_next;

  // Clamp the geometry registers to the supported frame
  always_comb begin
    if (frame_width == '0) begin
      last_col = '0;
    end else if ({1'b0, frame_width} > 13'(WLIM)) begin
      last_col = CW'(WLIM - 1);
    end else begin
      last_col = CW'(frame_width - 12'd1);
    end
    if (frame_height == '0) begin
      last_row = '0;
    end else if ({1'b0, frame_height} > 14'(HLIM)) begin
      last_row = RW'(HLIM - 1);
    end else begin
      last_row = RW'(frame_height - 13'd1);
    end
  end

  assign s1_adv   = s1_valid && (!qstat.full || (s1_mask == '0));
  assign s_tready = !s1_valid || s1_adv;
  assign in_acc   = s_tvalid && s_tready;
  assign q_push   = s1_adv && (s1_mask != '0);

  // Raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (restart) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Classify the pixel at transfer and hold it while the line store reads
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix     <= s_tdata;
      s1_col     <= col;
      s1_row_out <= 12'(row);
      s1_col_out <= 11'(col);
      s1_r_ge1   <= (row != '0);
      s1_r_ge2   <= (row > RW'(1));
      s1_c_ge1   <= (col != '0);
      s1_c_ge2   <= (col > CW'(1));
      s1_mask[0] <= (row != '0) && (col != '0);
      s1_mask[1] <= (row != '0) && (col == last_col);
      s1_mask[2] <= (row == last_row) && (col != '0);
      s1_mask[3] <= (row == last_row) && (col == last_col);
    end
  end

  // Line stores: upper row in the high byte, middle row in the low byte
  ced3x3_ram #(
    .WIDTH (16),
    .DEPTH (WLIM)
  ) u_lines (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (wr_word),
    .re    (in_acc),
    .raddr (col),
    .rdata (rd_word)
  );

  // Forward a write that lands on the address being read (one-pixel rows)
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (in_acc) begin
      fwd <= s1_adv && (col == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_word <= wr_word;
    end
  end

  assign col_word  = fwd ? fwd_word : rd_word;
  assign upper_old = col_word[15:8];
  assign mid_old   = col_word[7:0];
  assign wr_word   = {mid_old, s1_pix};

  // Shift the window left and load the new right column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k*3]   = win[k*3+1];
      win_next[k*3+1] = win[k*3+2];
    end
    win_next[2] = upper_old;
    win_next[5] = mid_old;
    win_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win <= win_next;
    end
  end

  // Entry handed to the back part
  always_comb begin
    q_entry.win   = win_next;
    q_entry.row   = s1_row_out;
    q_entry.col   = s1_col_out;
    q_entry.r_ge1 = s1_r_ge1;
    q_entry.r_ge2 = s1_r_ge2;
    q_entry.c_ge1 = s1_c_ge1;
    q_entry.c_ge2 = s1_c_ge2;
    q_entry.mask  = s1_mask;
  end

endmodule
`default_nettype wire

[sv/ced3x3_back.sv]
`default_nettype none
module ced3x3_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ced3x3_pkg::entry_t  head,
  input  wire ced3x3_pkg::qstat_t  qstat,
  input  wire logic [7:0]          threshold,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata,   // [7:0] value, [19:8] row_index,
                                              // [30:20] col_index, [31] zero
  output logic                     m_tlast,   // last_of_run
  output logic                     m_tuser    // [0] end_of_frame
);
  import ced3x3_pkg::*;

  // Which window cell a result comes from
  typedef enum logic [1:0] {
    POS_CENTRE = 2'd0,
    POS_RIGHT  = 2'd1,
    POS_BOTTOM = 2'd2,
    POS_CORNER = 2'd3
  } pos_t;

  logic [3:0]            done;
  logic [3:0]            pend;
  logic [3:0]            sel_oh;
  logic [3:0]            rest;
  pos_t                  sel;
  logic                  load;
  logic [3:0][3:0][7:0]  pad;
  logic [1:0]            cr;
  logic [1:0]            cc;
  logic [7:0]            centre;
  logic                  up;
  logic                  dn;
  logic                  lf;
  logic                  rt;
  logic [7:0]            mn;
  logic [7:0]            mx;
  logic [7:0]            value;
  logic [11:0]           row_o;
  logic [10:0]           col_o;

  // Pick the next pending result of the head entry
  always_comb begin
    pend = head.mask & ~done;
    if (pend[0]) begin
      sel = POS_CENTRE;
    end else if (pend[1]) begin
      sel = POS_RIGHT;
    end else if (pend[2]) begin
      sel = POS_BOTTOM;
    end else begin
      sel = POS_CORNER;
    end
    sel_oh = 4'b0001 << sel;
    rest   = pend & ~sel_oh;
  end

  // Neighbour min and max around the selected cell
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pad[i][j] = (i < 3 && j < 3) ? head.win[i*3+j] : 8'd0;
      end
    end
    cr     = sel[1] ? 2'd2 : 2'd1;
    cc     = sel[0] ? 2'd2 : 2'd1;
    centre = pad[cr][cc];
    up     = sel[1] ? head.r_ge1 : head.r_ge2;
    dn     = !sel[1];
    lf     = sel[0] ? head.c_ge1 : head.c_ge2;
    rt     = !sel[0];
    mn     = 8'hFF;
    mx     = 8'h00;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        logic [1:0] ri;
        logic [1:0] cj;
        logic       ok;
        logic [7:0] nb;
        ri = cr + 2'(i) - 2'd1;
        cj = cc + 2'(j) - 2'd1;
        ok = ((i == 0) ? up : ((i == 2) ? dn : 1'b1)) &&
             ((j == 0) ? lf : ((j == 2) ? rt : 1'b1));
        nb = ok ? pad[ri][cj] : centre;
        if (!(i == 1 && j == 1)) begin
          if (nb < mn) mn = nb;
          if (nb > mx) mx = nb;
        end
      end
    end
    if (centre == 8'd0) begin
      value = 8'd0;
    end else if (mn <= threshold) begin
      value = mx;
    end else begin
      value = centre;
    end
    row_o = sel[1] ? head.row : head.row - 12'd1;
    col_o = sel[0] ? head.col : head.col - 11'd1;
  end

  assign load = !qstat.empty && (!m_tvalid || m_tready);
  assign pop  = load && (rest == '0);

  // Track results already sent for the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (pop) begin
      done <= '0;
    end else if (load) begin
      done <= done | sel_oh;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {1'b0, col_o, row_o, value};
      m_tlast <= (rest == '0);
      m_tuser <= (sel == POS_CORNER);
    end
  end

endmodule
`default_nettype wire

[sv/conditional_edge_dilation_3x3_core.sv]
// Conditional 3x3 dilation over a raster pixel stream.
// Input: s_tvalid/s_tready/s_tdata carry one 8-bit pixel per transfer in raster
// order. Output: m_tvalid/m_tready/m_tdata carry one result per transfer with
// its value, row and column; m_tlast marks the last result caused by one input
// pixel and m_tuser marks the bottom right pixel of the frame.
// A result for a pixel leaves once its lower right neighbour has arrived; the
// first result passes the classify register, the queue and the output register.
// The front accepts one pixel per cycle while the queue has room; the back sends
// one result per cycle while m_tready is high, so pixels at a row end and on the
// last row (two to four results each) fill the four-entry queue; while it is
// full, a pixel that causes results holds s_tready low until one entry leaves.
// A stalled receiver fills the queue and then stalls the input.
// Configuration goes through the APB port: threshold at 0x0, frame width at
// 0x4, frame height at 0x8. Writing width or height restarts the frame at row
// zero, column zero; write only while the stream is idle.
// Reset clears the position counters, queue and output valid and loads the
// default registers (threshold 0, 640 x 480). Line store contents are left
// as they are; entries not yet written in a frame never reach a result.
`default_nettype none
`include "conditional_edge_dilation_3x3_core_macros.svh"
module conditional_edge_dilation_3x3_core #(
  parameter int MAX_WIDTH  = ced3x3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ced3x3_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Pixel stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] pixel
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,    // [7:0] value, [19:8] row_index,
                                       // [30:20] col_index, [31] zero
  output logic             m_tlast,    // last_of_run
  output logic             m_tuser,    // [0] end_of_frame
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ced3x3_pkg::*;

  logic [7:0]  threshold;
  logic [11:0] frame_width;
  logic [12:0] frame_height;
  logic        cfg_wr;
  logic        restart;
  logic [1:0]  reg_idx;

  logic        q_push;
  entry_t      q_entry;
  logic        q_pop;
  entry_t      q_head;
  qstat_t      qstat;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: threshold    <= pwdata[7:0];
        REG_WIDTH:     frame_width  <= pwdata[11:0];
        REG_HEIGHT:    frame_height <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = 32'(threshold);
      REG_WIDTH:     prdata = 32'(frame_width);
      REG_HEIGHT:    prdata = 32'(frame_height);
      default:       prdata = '0;
    endcase
  end

  // Front: accept, line stores, window, classify
  ced3x3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .restart      (restart),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .qstat        (qstat),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // Queue between front and back
  ced3x3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (qstat)
  );

  // Back: evaluate and send results one per cycle while the receiver is ready
  ced3x3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .qstat     (qstat),
    .threshold (threshold),
    .pop       (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // Checks
  `CED3X3_ASSERT_IMP(a_eof_ends_run, clk, rst, m_tvalid && m_tuser, m_tlast)
  `CED3X3_ASSERT_IMP(a_stall_needs_full_queue, clk, rst, !s_tready, qstat.full)
  `CED3X3_ASSERT_NXT(a_queue_feeds_output, clk, rst, !qstat.empty && (!m_tvalid || m_tready), m_tvalid)

endmodule
`default_nettype wire
